// ===== rtl/fcp_pkg.sv =====
// fcp_pkg: shared types and constants of the framed command parser
package fcp_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned CFG_IDX_W = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HEAD  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL  = 8'd3;

  // register reset values
  localparam logic [BYTE_W-1:0] HEAD_RST  = 8'h5a;
  localparam logic [BYTE_W-1:0] TYPE_RST  = 8'h01;
  localparam logic [BYTE_W-1:0] CHECK_RST = 8'hff;
  localparam logic [BYTE_W-1:0] TAIL_RST  = 8'ha5;

  // length byte counts head, length, type, check and tail
  localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd5;
  localparam logic [BYTE_W-1:0] LEN_MIN_DATA = 8'd6;

  // parser phases, plus the two burst steps
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_TYPE  = 3'd2,
    PH_BODY  = 3'd3,
    PH_CHECK = 3'd4,
    PH_TAIL  = 3'd5,
    PH_READ  = 3'd6,
    PH_EMIT  = 3'd7
  } phase_t;

  // controller to datapath
  typedef struct packed {
    logic ld_len;   // capture length byte, clear fill count
    logic wr_body;  // store body byte at fill count
    logic clr_pos;  // start a result burst
    logic rd_body;  // read data byte for current position
    logic ld_out;   // load the output register
    logic inc_pos;  // step to next data position
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic head_hit;
    logic type_hit;
    logic check_hit;
    logic tail_hit;
    logic len_bad;     // declared body does not fit the store
    logic body_done;   // this body byte is the final one
    logic burst_last;  // current position is the final result
    logic slot_free;   // output register can take a word
  } ctl_stat_t;

endpackage

// ===== rtl/fcp_chan_if.sv =====
// fcp_chan_if: valid/ready channel interfaces for bytes, results and config writes
interface fcp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] command;
  logic [5:0] data_count;
  logic [5:0] position;
  logic [7:0] data_byte;
  logic       has_data;
  logic       last;

  modport source (output valid, output command, output data_count, output position,
                  output data_byte, output has_data, output last, input ready);
  modport sink   (input valid, input command, input data_count, input position,
                  input data_byte, input has_data, input last, output ready);
endinterface

interface fcp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fcp_ctrl.sv =====
// fcp_ctrl: frame parsing state machine and result burst sequencing
module fcp_ctrl
  import fcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  phase_t state_r, state_nxt;
  logic   in_fire;

  assign in_fire = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PH_HUNT: begin
        if (in_fire && stat.head_hit) state_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (in_fire) state_nxt = stat.len_bad ? PH_HUNT : PH_TYPE;
      end
      PH_TYPE: begin
        if (in_fire) state_nxt = stat.type_hit ? PH_BODY : PH_HUNT;
      end
      PH_BODY: begin
        if (in_fire && stat.body_done) state_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        if (in_fire) state_nxt = stat.check_hit ? PH_TAIL : PH_HUNT;
      end
      PH_TAIL: begin
        if (in_fire) state_nxt = stat.tail_hit ? PH_READ : PH_HUNT;
      end
      PH_READ: begin
        state_nxt = PH_EMIT;
      end
      PH_EMIT: begin
        if (stat.slot_free) state_nxt = stat.burst_last ? PH_HUNT : PH_READ;
      end
      default: begin
        state_nxt = PH_HUNT;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      PH_HUNT, PH_TYPE, PH_CHECK: begin
        in_ready = 1'b1;
      end
      PH_LEN: begin
        in_ready   = 1'b1;
        cmd.ld_len = in_valid;
      end
      PH_BODY: begin
        in_ready    = 1'b1;
        cmd.wr_body = in_valid;
      end
      PH_TAIL: begin
        in_ready    = 1'b1;
        cmd.clr_pos = in_valid && stat.tail_hit;
      end
      PH_READ: begin
        cmd.rd_body = 1'b1;
      end
      PH_EMIT: begin
        cmd.ld_out  = stat.slot_free;
        cmd.inc_pos = stat.slot_free && !stat.burst_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/fcp_datapath.sv =====
// fcp_datapath: config registers, body store, counters and output register
module fcp_datapath
  import fcp_pkg::*;
#(
  parameter int unsigned BODY_DEPTH = 64
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              cfg_fire,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0] cfg_data,
  input  ctl_cmd_t          cmd,
  output ctl_stat_t         stat,
  fcp_res_if.source         out_res
);

  localparam int unsigned ADDR_W = $clog2(BODY_DEPTH);
  localparam int unsigned FILL_W = $clog2(BODY_DEPTH + 1);

  logic [BYTE_W-1:0] head_r, type_r, check_r, tail_r;
  logic [FILL_W-1:0] needed_r;
  logic [FILL_W-1:0] fill_r;
  logic [ADDR_W-1:0] pos_r;
  logic [BYTE_W-1:0] cmd_byte_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] body_mem [BODY_DEPTH];

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_cmd_r, out_data_r;
  logic [COUNT_W-1:0] out_count_r, out_pos_r;
  logic              out_has_r, out_last_r;

  logic [BYTE_W-1:0] len_needed;
  logic [ADDR_W-1:0] data_cnt;
  logic              cnt_zero;
  logic [ADDR_W-1:0] rd_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= HEAD_RST;
      type_r  <= TYPE_RST;
      check_r <= CHECK_RST;
      tail_r  <= TAIL_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_HEAD:  head_r  <= cfg_data;
        REG_TYPE:  type_r  <= cfg_data;
        REG_CHECK: check_r <= cfg_data;
        REG_TAIL:  tail_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // body byte count from the length byte: max(len-5,1)
  assign len_needed = (rx_byte > LEN_MIN_DATA) ? (rx_byte - LEN_OVERHEAD) : 8'd1;

  // length and fill counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r <= '0;
      fill_r   <= '0;
    end else if (cmd.ld_len) begin
      needed_r <= FILL_W'(len_needed);
      fill_r   <= '0;
    end else if (cmd.wr_body) begin
      fill_r <= fill_r + FILL_W'(1);
    end
  end

  // body store, command kept aside
  always_ff @(posedge clk) begin
    if (cmd.wr_body) begin
      body_mem[fill_r[ADDR_W-1:0]] <= rx_byte;
      if (fill_r == '0) cmd_byte_r <= rx_byte;
    end
  end

  // registered read of the data byte after the command
  assign rd_addr = pos_r + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.rd_body) rd_data_r <= body_mem[rd_addr];
  end

  // burst position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.clr_pos) begin
      pos_r <= '0;
    end else if (cmd.inc_pos) begin
      pos_r <= pos_r + ADDR_W'(1);
    end
  end

  assign data_cnt = ADDR_W'(needed_r - FILL_W'(1));
  assign cnt_zero = (data_cnt == '0);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_cmd_r   <= cmd_byte_r;
      out_count_r <= COUNT_W'(data_cnt);
      out_pos_r   <= cnt_zero ? '0 : COUNT_W'(pos_r);
      out_data_r  <= cnt_zero ? '0 : rd_data_r;
      out_has_r   <= !cnt_zero;
      out_last_r  <= stat.burst_last;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.command    = out_cmd_r;
  assign out_res.data_count = out_count_r;
  assign out_res.position   = out_pos_r;
  assign out_res.data_byte  = out_data_r;
  assign out_res.has_data   = out_has_r;
  assign out_res.last       = out_last_r;

  // status toward the controller
  always_comb begin
    stat.head_hit   = (rx_byte == head_r);
    stat.type_hit   = (rx_byte == type_r);
    stat.check_hit  = (rx_byte == check_r);
    stat.tail_hit   = (rx_byte == tail_r);
    stat.len_bad    = ({1'b0, len_needed} > 9'(BODY_DEPTH));
    stat.body_done  = ((fill_r + FILL_W'(1)) == needed_r);
    stat.burst_last = cnt_zero || ((pos_r + ADDR_W'(1)) == data_cnt);
    stat.slot_free  = !out_valid_r || out_res.ready;
  end

endmodule

// ===== rtl/framed_command_parser.sv =====
// framed_command_parser: top level of the head/length/type/body/check/tail frame parser
//
// Usage
//   in_rx carries one received byte per word. The parser hunts for the head byte,
//   takes the length byte and the type byte, stores max(length-5,1) body bytes
//   (the first is the command), then checks the check and tail bytes.
//   On a good tail, out_res gives one word per data byte with command, data
//   count, position and a last mark; a frame without data gives a single word
//   with has_data low. Any mismatch drops the frame and the parser hunts again.
//   cfg_wr writes head, type, check and tail bytes (index 0..3); it is always
//   ready and other indexes are ignored.
// Timing
//   Received bytes are taken without stalls while a frame is parsed. After the tail,
//   each result takes a registered read of the body store followed by the output
//   register load, and the next read waits for that load; the first result passes
//   the read and the load after the tail is taken. in_rx is held not ready during the burst.
// Reset and stalls
//   Synchronous active-low reset restores the register defaults and the hunt
//   phase; the body store is not cleared. A stalled receiver holds the output
//   word and pauses the burst; bytes are still taken while the final word waits.
module framed_command_parser
  import fcp_pkg::*;
#(
  parameter int unsigned BODY_DEPTH = 64
)(
  input  logic      clk,
  input  logic      rst_n,
  fcp_rx_if.sink    in_rx,
  fcp_res_if.source out_res,
  fcp_cfg_if.sink   cfg_wr
);

  ctl_cmd_t  ctl_cmd;
  ctl_stat_t ctl_stat;
  logic      cfg_fire;

  // config port never stalls
  assign cfg_wr.ready = 1'b1;
  assign cfg_fire     = cfg_wr.valid && cfg_wr.ready;

  fcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_rx.valid),
    .in_ready (in_rx.ready),
    .stat     (ctl_stat),
    .cmd      (ctl_cmd)
  );

  fcp_datapath #(
    .BODY_DEPTH (BODY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_byte   (in_rx.rx_byte),
    .cfg_fire  (cfg_fire),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .cmd       (ctl_cmd),
    .stat      (ctl_stat),
    .out_res   (out_res)
  );

  // a load never overwrites a result that was not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.ld_out |-> (!out_res.valid || out_res.ready))
    else $error("output word overwritten before it was taken");

  // no byte is taken right after a body read
  a_read_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.rd_body |=> !in_rx.ready)
    else $error("input accepted during result burst");

  // a result without data is always the lone final word with zero count
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.has_data) |-> (out_res.last && (out_res.data_count == 6'd0)))
    else $error("empty result malformed");

  // a body write and a burst read never coincide
  a_write_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl_cmd.wr_body && (ctl_cmd.rd_body || ctl_cmd.ld_out)))
    else $error("body store written during burst");

endmodule
